/* design/edist_pkg.sv */
// Shared widths, types and constants for the 4-D Euclidean distance pipeline.
package edist_pkg;

  // Component width; every other width follows from it.
  localparam int SAMPLE_BITS = 16;
  localparam int OUT_BITS    = SAMPLE_BITS + 2;

  // Datapath widths
  localparam int MAG_W  = SAMPLE_BITS;       // |a - b| never exceeds 2^SB - 1
  localparam int SQ_W   = 2 * MAG_W;         // one squared difference
  localparam int PAIR_W = SQ_W + 1;          // sum of two squares
  localparam int SUM_W  = SQ_W + 2;          // sum of four squares
  localparam int ROOT_W = SUM_W / 2;         // integer root of the sum
  localparam int REM_W  = ROOT_W + 2;        // partial remainder of the root

  // Pipeline depths
  localparam int LANES        = 4;
  localparam int FRONT_STAGES = 4;           // diff, square, pair add, final add
  localparam int SQRT_STAGES  = ROOT_W;      // one root bit per stage

  // Largest distance the block can produce: 2 * (2^SB - 1)
  localparam logic [OUT_BITS-1:0] MAX_DIST =
    OUT_BITS'((64'd1 << (SAMPLE_BITS + 1)) - 64'd2);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [OUT_BITS-1:0]           dist_t;
  typedef logic [SUM_W-1:0]              sum_t;

endpackage

/* design/edist_sqrt.sv */
// Pipelined integer square root, one root bit resolved per register stage.
module edist_sqrt (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  edist_pkg::sum_t       radicand_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output edist_pkg::dist_t      root_o
);
  import edist_pkg::*;

  logic              v_q    [SQRT_STAGES];
  logic              rdy    [SQRT_STAGES+1];
  logic [SUM_W-1:0]  rad_q  [SQRT_STAGES];
  logic [REM_W-1:0]  rem_q  [SQRT_STAGES];
  logic [ROOT_W-1:0] root_q [SQRT_STAGES];

  assign rdy[SQRT_STAGES] = out_ready_i;

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    logic              v_prev;
    logic [SUM_W-1:0]  rad_prev;
    logic [REM_W-1:0]  rem_prev;
    logic [ROOT_W-1:0] root_prev;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic [REM_W-1:0]  rem_d;
    logic [ROOT_W-1:0] root_d;
    logic [SUM_W-1:0]  rad_d;

    // Stage inputs: the radicand port for the first stage, else the stage before
    if (s == 0) begin : g_first
      assign v_prev    = in_valid_i;
      assign rad_prev  = radicand_i;
      assign rem_prev  = '0;
      assign root_prev = '0;
    end else begin : g_next
      assign v_prev    = v_q[s-1];
      assign rad_prev  = rad_q[s-1];
      assign rem_prev  = rem_q[s-1];
      assign root_prev = root_q[s-1];
    end

    // A stage moves when it is empty or its successor moves
    assign rdy[s] = !v_q[s] || rdy[s+1];

    // Bring down two radicand bits, try subtracting 4*root + 1
    always_comb begin
      rem_sh = {rem_prev, rad_prev[SUM_W-1 -: 2]};
      trial  = (REM_W+2)'({root_prev, 2'b01});
      rad_d  = rad_prev << 2;
      if (rem_sh >= trial) begin
        rem_d  = REM_W'(rem_sh - trial);
        root_d = {root_prev[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = REM_W'(rem_sh);
        root_d = {root_prev[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_q[s] <= v_prev;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s] && v_prev) begin
        rad_q[s]  <= rad_d;
        rem_q[s]  <= rem_d;
        root_q[s] <= root_d;
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[SQRT_STAGES-1];
  assign root_o      = OUT_BITS'(root_q[SQRT_STAGES-1]);

endmodule

/* design/euclidean_distance_4d.sv */
// Top level: 4-D Euclidean distance of two Q1.15 points, fully pipelined.
// Pipeline: 4 arithmetic stages followed by 17 square-root stages, one root bit
// resolved per stage.
// Throughput: one item per cycle unless the output stalls; a stage holds its
// item while the next is full and stalled; a stall loses and repeats nothing.
// Reset: rst_ni is asynchronous active low and clears all stage valid bits;
// data registers are not reset.
module euclidean_distance_4d (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  edist_pkg::sample_t  a_w_i,
  input  edist_pkg::sample_t  a_x_i,
  input  edist_pkg::sample_t  a_y_i,
  input  edist_pkg::sample_t  a_z_i,
  input  edist_pkg::sample_t  b_w_i,
  input  edist_pkg::sample_t  b_x_i,
  input  edist_pkg::sample_t  b_y_i,
  input  edist_pkg::sample_t  b_z_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output edist_pkg::dist_t    distance_o
);
  import edist_pkg::*;

  logic             v_q  [FRONT_STAGES];
  logic             rdy  [FRONT_STAGES+1];
  sample_t          a_in [LANES];
  sample_t          b_in [LANES];
  logic [MAG_W-1:0] mag_d  [LANES];
  logic [MAG_W-1:0] mag_q  [LANES];
  logic [SQ_W-1:0]  sq_q   [LANES];
  logic [PAIR_W-1:0] pair_q [2];
  sum_t             sum_q;
  logic             sqrt_ready;

  assign a_in[0] = a_w_i;
  assign a_in[1] = a_x_i;
  assign a_in[2] = a_y_i;
  assign a_in[3] = a_z_i;
  assign b_in[0] = b_w_i;
  assign b_in[1] = b_x_i;
  assign b_in[2] = b_y_i;
  assign b_in[3] = b_z_i;

  // Per-stage handshake: a stage moves when empty or when its successor moves
  assign rdy[FRONT_STAGES] = sqrt_ready;
  for (genvar k = 0; k < FRONT_STAGES; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end
  assign in_ready_o = rdy[0];

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < FRONT_STAGES; k++) v_q[k] <= 1'b0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < FRONT_STAGES; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Exact difference and its magnitude for each lane
  always_comb begin
    logic signed [SAMPLE_BITS:0] diff;
    for (int l = 0; l < LANES; l++) begin
      diff     = {a_in[l][SAMPLE_BITS-1], a_in[l]} - {b_in[l][SAMPLE_BITS-1], b_in[l]};
      mag_d[l] = diff[SAMPLE_BITS] ? MAG_W'(-diff) : MAG_W'(diff);
    end
  end

  // Stage 0: magnitudes
  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      for (int l = 0; l < LANES; l++) mag_q[l] <= mag_d[l];
    end
  end

  // Stage 1: squares
  always_ff @(posedge clk_i) begin
    if (rdy[1] && v_q[0]) begin
      for (int l = 0; l < LANES; l++) sq_q[l] <= SQ_W'(mag_q[l]) * SQ_W'(mag_q[l]);
    end
  end

  // Stage 2: pairwise sums
  always_ff @(posedge clk_i) begin
    if (rdy[2] && v_q[1]) begin
      pair_q[0] <= PAIR_W'(sq_q[0]) + PAIR_W'(sq_q[1]);
      pair_q[1] <= PAIR_W'(sq_q[2]) + PAIR_W'(sq_q[3]);
    end
  end

  // Stage 3: sum of all four squares
  always_ff @(posedge clk_i) begin
    if (rdy[3] && v_q[2]) begin
      sum_q <= SUM_W'(pair_q[0]) + SUM_W'(pair_q[1]);
    end
  end

  // Root stages; the last one is the output register
  edist_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v_q[FRONT_STAGES-1]),
    .in_ready_o  (sqrt_ready),
    .radicand_i  (sum_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .root_o      (distance_o)
  );

endmodule

/* design/edist_checker.sv */
// Port-level checks for the distance pipeline, bound to the top level.
module edist_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_ready_o,
  input  logic                out_valid_o,
  input  logic                out_ready_i,
  input  edist_pkg::dist_t    distance_o
);
  import edist_pkg::*;

  // Reset empties the pipeline by the next edge
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

  // A stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(distance_o))
    else $error("stalled result changed or dropped");

  // Backpressure at the input only when every stage is full and the output stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while output is free");

  // No distance exceeds the largest possible value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> distance_o <= MAX_DIST)
    else $error("distance out of range");

endmodule

bind euclidean_distance_4d edist_checker u_edist_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .distance_o  (distance_o)
);

/* sim/euclidean_distance_4d_tb.sv */
// Testbench for euclidean_distance_4d: directed and random point pairs checked against a predictor.
`timescale 1ns / 1ps

module euclidean_distance_4d_tb;
  import edist_pkg::*;

  localparam int CLK_HALF    = 2;
  localparam int LATENCY     = 21;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_PCT    = 38;
  localparam int RAND_ITEMS  = 1800;

  // One input item: two points in four dimensions
  typedef struct {
    sample_t a[4];
    sample_t b[4];
  } point_pair_t;

  // One expected distance, tagged with the item number for messages
  typedef struct {
    int    idx;
    dist_t dist_val;
  } dist_expect_t;

  // Kinds of component values the random generator draws from
  typedef enum int {
    GEN_UNIFORM,
    GEN_EDGE,
    GEN_NEAR,
    GEN_EQUAL
  } gen_mode_e;

  logic    clk_i       = 1'b0;
  logic    rst_ni      = 1'b0;
  logic    in_valid_i  = 1'b0;
  logic    in_ready_o;
  sample_t a_w_i       = '0;
  sample_t a_x_i       = '0;
  sample_t a_y_i       = '0;
  sample_t a_z_i       = '0;
  sample_t b_w_i       = '0;
  sample_t b_x_i       = '0;
  sample_t b_y_i       = '0;
  sample_t b_z_i       = '0;
  logic    out_valid_o;
  logic    out_ready_i = 1'b0;
  dist_t   distance_o;

  dist_expect_t pending_dist[$];
  int           items_sent   = 0;
  int           dists_seen   = 0;
  int           mismatches   = 0;
  int           cycle_count  = 0;
  bit           steady_flow  = 1'b0;   // no idling on either side while set
  bit           rx_enable    = 1'b0;

  euclidean_distance_4d u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .a_w_i       (a_w_i),
    .a_x_i       (a_x_i),
    .a_y_i       (a_y_i),
    .a_z_i       (a_z_i),
    .b_w_i       (b_w_i),
    .b_x_i       (b_x_i),
    .b_y_i       (b_y_i),
    .b_z_i       (b_z_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .distance_o  (distance_o)
  );

  // Clock
  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d distances still pending", $realtime, pending_dist.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Exact distance: sum of squared differences, then integer root truncated
  function automatic dist_t predict_distance(point_pair_t p);
    longint diff;
    longint unsigned sq_sum;
    longint unsigned root;
    longint unsigned cand;
    sq_sum = 0;
    for (int k = 0; k < 4; k++) begin
      diff   = longint'(p.a[k]) - longint'(p.b[k]);
      sq_sum = sq_sum + longint'(diff * diff);
    end
    root = 0;
    for (int b_idx = OUT_BITS - 1; b_idx >= 0; b_idx--) begin
      cand = root | (64'd1 << b_idx);
      if (cand * cand <= sq_sum) root = cand;
    end
    return dist_t'(root);
  endfunction

  // Receiver: random back-pressure unless in a steady stretch
  always @(posedge clk_i) begin
    if (!rx_enable) begin
      out_ready_i <= 1'b0;
    end else if (steady_flow) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Scoreboard: check the result leaving, then record the item entering
  always @(posedge clk_i) begin
    point_pair_t  acc;
    dist_expect_t exp_d;
    if (rst_ni && out_valid_o && out_ready_i) begin
      dists_seen++;
      if (pending_dist.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected distance, expected none, actual %0d",
                 $realtime, distance_o);
      end else begin
        exp_d = pending_dist.pop_front();
        if (distance_o !== exp_d.dist_val) begin
          mismatches++;
          $display("%0t: item %0d distance mismatch, expected %0d, actual %0d",
                   $realtime, exp_d.idx, exp_d.dist_val, distance_o);
        end
      end
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      acc.a[0] = a_w_i; acc.a[1] = a_x_i; acc.a[2] = a_y_i; acc.a[3] = a_z_i;
      acc.b[0] = b_w_i; acc.b[1] = b_x_i; acc.b[2] = b_y_i; acc.b[3] = b_z_i;
      exp_d.idx      = items_sent;
      exp_d.dist_val = predict_distance(acc);
      pending_dist.push_back(exp_d);
      items_sent++;
    end
  end

  // Send one item; returns at the edge where it is accepted
  task automatic send_pair(point_pair_t p);
    int gap;
    gap = 0;
    if (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(8, 2) : 1;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    a_w_i <= p.a[0]; a_x_i <= p.a[1]; a_y_i <= p.a[2]; a_z_i <= p.a[3];
    b_w_i <= p.b[0]; b_x_i <= p.b[1]; b_y_i <= p.b[2]; b_z_i <= p.b[3];
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Build a pair with every component of a and of b set to one value
  function automatic point_pair_t uniform_pair(sample_t av, sample_t bv);
    point_pair_t p;
    for (int k = 0; k < 4; k++) begin
      p.a[k] = av;
      p.b[k] = bv;
    end
    return p;
  endfunction

  function automatic sample_t rand_sample();
    return sample_t'($urandom_range(16'hFFFF));
  endfunction

  function automatic sample_t edge_sample();
    case ($urandom_range(5))
      0:       return sample_t'(16'h8000);
      1:       return sample_t'(16'h7FFF);
      2:       return sample_t'(16'hFFFF);
      3:       return sample_t'(16'h0000);
      4:       return sample_t'(16'h0001);
      default: return sample_t'(16'h8001);
    endcase
  endfunction

  // Random pair; near and equal modes exercise small roots and truncation
  function automatic point_pair_t random_pair(gen_mode_e mode);
    point_pair_t p;
    for (int k = 0; k < 4; k++) begin
      case (mode)
        GEN_EDGE: begin
          p.a[k] = edge_sample();
          p.b[k] = ($urandom_range(1) == 0) ? edge_sample() : rand_sample();
        end
        GEN_NEAR: begin
          p.a[k] = rand_sample();
          p.b[k] = p.a[k] + sample_t'($urandom_range(6) - 3);
        end
        GEN_EQUAL: begin
          p.a[k] = rand_sample();
          p.b[k] = p.a[k];
        end
        default: begin
          p.a[k] = rand_sample();
          p.b[k] = rand_sample();
        end
      endcase
    end
    return p;
  endfunction

  function automatic gen_mode_e pick_mode();
    int r;
    r = $urandom_range(99);
    if (r < 70) return GEN_UNIFORM;
    if (r < 82) return GEN_EDGE;
    if (r < 95) return GEN_NEAR;
    return GEN_EQUAL;
  endfunction

  // Hold the sender until every expected distance has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_dist.size() != 0) @(posedge clk_i);
  endtask

  // Equal points, zero and otherwise, give a zero distance
  task automatic test_equal_points();
    send_pair(uniform_pair(sample_t'(0), sample_t'(0)));
    send_pair(uniform_pair(sample_t'(16'h8000), sample_t'(16'h8000)));
    send_pair(uniform_pair(sample_t'(16'h7FFF), sample_t'(16'h7FFF)));
    send_pair(random_pair(GEN_EQUAL));
  endtask

  // Full-scale corners, including the largest distance
  task automatic test_extremes();
    send_pair(uniform_pair(sample_t'(16'h8000), sample_t'(16'h7FFF)));
    send_pair(uniform_pair(sample_t'(16'h7FFF), sample_t'(16'h8000)));
    send_pair(uniform_pair(sample_t'(16'h8000), sample_t'(0)));
    send_pair(uniform_pair(sample_t'(0), sample_t'(16'h7FFF)));
    send_pair(uniform_pair(sample_t'(16'hFFFF), sample_t'(16'h0001)));
  endtask

  // Largest difference on one axis at a time, both signs
  task automatic test_axis_extremes();
    point_pair_t p;
    for (int k = 0; k < 4; k++) begin
      p = uniform_pair(sample_t'(0), sample_t'(0));
      p.a[k] = sample_t'(16'h7FFF);
      p.b[k] = sample_t'(16'h8000);
      send_pair(p);
      p.a[k] = sample_t'(16'h8000);
      p.b[k] = sample_t'(16'h7FFF);
      send_pair(p);
    end
  endtask

  // Alternating bit patterns so every input bit toggles
  task automatic test_bit_patterns();
    send_pair(uniform_pair(sample_t'(16'h5555), sample_t'(16'hAAAA)));
    send_pair(uniform_pair(sample_t'(16'hAAAA), sample_t'(16'h5555)));
    send_pair(uniform_pair(sample_t'(16'h0001), sample_t'(16'h0000)));
    send_pair(uniform_pair(sample_t'(16'h0000), sample_t'(16'hFFFF)));
  endtask

  // Random stream with idling on both sides and one drain pause
  task automatic test_random_stream(int count);
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) wait_drained();
      send_pair(random_pair(pick_mode()));
    end
  endtask

  // Back-to-back items with the receiver always ready
  task automatic test_steady_stream(int count);
    steady_flow = 1'b1;
    for (int n = 0; n < count; n++) send_pair(random_pair(pick_mode()));
    steady_flow = 1'b0;
  endtask

  // Test sequence
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni    <= 1'b1;
    rx_enable <= 1'b1;
    @(posedge clk_i);

    test_equal_points();
    test_extremes();
    test_axis_extremes();
    test_bit_patterns();
    wait_drained();
    test_random_stream(RAND_ITEMS * 2 / 3);
    test_steady_stream(RAND_ITEMS / 6);
    test_random_stream(RAND_ITEMS / 6);
    in_valid_i <= 1'b0;

    while (pending_dist.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);

    $display("Ran %0d point pairs (corners, single axes, bit patterns, random) and checked %0d",
             items_sent, dists_seen);
    $display("distances under random back-pressure, a steady stretch and a drain pause.");
    if (mismatches == 0 && pending_dist.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d distances never arrived", mismatches, pending_dist.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
